// ----- sv/skit_pkg.sv -----
`default_nettype none
package skit_pkg;

  typedef enum logic [1:0] {
    FUNC_CLEAR  = 2'd0,
    FUNC_INSERT = 2'd1,
    FUNC_LOOKUP = 2'd2
  } func_t;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_FOUND     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  localparam int ORDER_W = 10;

  typedef enum logic [3:0] {
    S_IDLE,
    S_IS_RD,
    S_IS_CMP,
    S_SH_RD,
    S_SH_WR,
    S_INS_WR,
    S_LK_RD,
    S_LK_CMP,
    S_LA_RD,
    S_LA_CMP,
    S_LB_RD,
    S_LB_CMP,
    S_RESULT
  } state_t;

  typedef struct packed {
    logic    load;
    logic    clear;
    logic    is_init;
    logic    is_step;
    logic    sh_init;
    logic    sh_rd;
    logic    sh_wr;
    logic    ins_wr;
    logic    lk_init;
    logic    lk_step;
    logic    rd_a;
    logic    rd_b;
    logic    set_found;
    logic    set_status;
    status_t status;
    logic    strobe;
  } cmd_t;

  typedef struct packed {
    logic    full;
    logic    empty;
    logic    key_zero;
    logic    is_more;
    logic    sh_more;
    logic    lk_more;
    logic    lk_hit;
    logic    hit;
    func_t   func;
  } stat_t;

endpackage
`default_nettype wire

// ----- sv/skit_datapath.sv -----
`default_nettype none
module skit_datapath #(
  parameter int TABLE_DEPTH = 1024
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic [1:0]                  func,
  input  wire logic [31:0]                 key,
  input  wire skit_pkg::cmd_t              cmd,
  output skit_pkg::stat_t                  stat,
  output logic [1:0]                       status,
  output logic [skit_pkg::ORDER_W-1:0]     order_number,
  output logic                             done
);
  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = AW + 1;

  logic [31:0]                  key_mem [TABLE_DEPTH];
  logic [skit_pkg::ORDER_W-1:0] ord_mem [TABLE_DEPTH];

  logic [31:0]                  key_reg;
  logic [1:0]                   func_reg;
  logic [CW-1:0]                count;
  logic [CW-1:0]                lo;
  logic [CW-1:0]                hi;
  logic [CW-1:0]                ptr;
  logic [AW-1:0]                rd_addr;
  logic [AW-1:0]                wr_addr;
  logic                         wr_en;
  logic [31:0]                  wr_key;
  logic [skit_pkg::ORDER_W-1:0] wr_ord;
  logic [31:0]                  rd_key;
  logic [skit_pkg::ORDER_W-1:0] rd_ord;
  logic [CW-1:0]                mid;
  logic [CW-1:0]                ptr_m1;

  assign mid    = lo + ((hi - lo) >> 1);
  assign ptr_m1 = ptr - CW'(1);

  always_comb begin
    rd_addr = mid[AW-1:0];
    if (cmd.sh_rd) begin
      rd_addr = ptr_m1[AW-1:0];
    end else if (cmd.rd_a) begin
      rd_addr = lo[AW-1:0];
    end else if (cmd.rd_b) begin
      rd_addr = hi[AW-1:0];
    end
    wr_en   = cmd.sh_wr | cmd.ins_wr;
    wr_addr = ptr[AW-1:0];
    if (cmd.sh_wr) begin
      wr_key = rd_key;
      wr_ord = rd_ord;
    end else begin
      wr_key = key_reg;
      wr_ord = skit_pkg::ORDER_W'(count);
    end
  end

  always_ff @(posedge clk) begin
    rd_key <= key_mem[rd_addr];
    rd_ord <= ord_mem[rd_addr];
    if (wr_en) begin
      key_mem[wr_addr] <= wr_key;
      ord_mem[wr_addr] <= wr_ord;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= cmd.strobe;
      if (cmd.clear) begin
        count <= '0;
      end else if (cmd.ins_wr) begin
        count <= count + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_reg  <= key;
      func_reg <= func;
    end
    if (cmd.is_init) begin
      lo <= '0;
      hi <= count;
    end else if (cmd.is_step) begin
      if (key_reg < rd_key) begin
        hi <= mid;
      end else begin
        lo <= mid + CW'(1);
      end
    end else if (cmd.lk_init) begin
      lo <= '0;
      hi <= count - CW'(1);
    end else if (cmd.lk_step) begin
      if (key_reg < rd_key) begin
        hi <= mid;
      end else begin
        lo <= mid;
      end
    end
    if (cmd.sh_init) begin
      ptr <= count;
    end else if (cmd.sh_wr) begin
      ptr <= ptr_m1;
    end
    if (cmd.set_status) begin
      status       <= cmd.status;
      order_number <= '0;
    end else if (cmd.set_found) begin
      status       <= skit_pkg::ST_FOUND;
      order_number <= rd_ord;
    end
  end

  always_comb begin
    stat.full     = (count == CW'(TABLE_DEPTH));
    stat.empty    = (count == '0);
    stat.key_zero = (key_reg == '0);
    stat.is_more  = (lo < hi);
    stat.sh_more  = (ptr > lo);
    stat.lk_more  = (hi > lo + CW'(1));
    stat.hit      = (rd_key == key_reg);
    stat.lk_hit   = (rd_key == key_reg);
    stat.func     = skit_pkg::func_t'(func_reg);
  end
endmodule
`default_nettype wire

// ----- sv/skit_ctrl.sv -----
`default_nettype none
module skit_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  input  wire skit_pkg::stat_t stat,
  output skit_pkg::cmd_t       cmd,
  output logic                 busy
);
  skit_pkg::state_t state;
  skit_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= skit_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      skit_pkg::S_IDLE: begin
        if (start) begin
          state_next = skit_pkg::S_RESULT;
        end
      end
      skit_pkg::S_RESULT: begin
        state_next = skit_pkg::S_IDLE;
      end
      skit_pkg::S_IS_RD: state_next = skit_pkg::S_IS_CMP;
      skit_pkg::S_IS_CMP: begin
        state_next = skit_pkg::S_IS_RD;
      end
      skit_pkg::S_SH_RD: state_next = skit_pkg::S_SH_WR;
      skit_pkg::S_SH_WR: state_next = skit_pkg::S_SH_RD;
      skit_pkg::S_INS_WR: state_next = skit_pkg::S_IDLE;
      skit_pkg::S_LK_RD: state_next = skit_pkg::S_LK_CMP;
      skit_pkg::S_LK_CMP: state_next = skit_pkg::S_LK_RD;
      skit_pkg::S_LA_RD: state_next = skit_pkg::S_LA_CMP;
      skit_pkg::S_LA_CMP: state_next = skit_pkg::S_LB_RD;
      skit_pkg::S_LB_RD: state_next = skit_pkg::S_LB_CMP;
      skit_pkg::S_LB_CMP: state_next = skit_pkg::S_IDLE;
      default: state_next = skit_pkg::S_IDLE;
    endcase
    // Decisions that depend on the decoded item.
    unique case (state)
      skit_pkg::S_IDLE: begin
        if (start) begin
          state_next = skit_pkg::S_RESULT;
        end
      end
      skit_pkg::S_RESULT: begin
        state_next = skit_pkg::S_IDLE;
        if (stat.func == skit_pkg::FUNC_INSERT && !stat.full) begin
          state_next = skit_pkg::S_IS_RD;
        end else if (stat.func == skit_pkg::FUNC_LOOKUP && !stat.key_zero &&
                     !stat.empty) begin
          state_next = skit_pkg::S_LK_RD;
        end
      end
      skit_pkg::S_IS_RD: begin
        if (!stat.is_more) begin
          state_next = skit_pkg::S_SH_RD;
        end
      end
      skit_pkg::S_SH_RD: begin
        if (!stat.sh_more) begin
          state_next = skit_pkg::S_INS_WR;
        end
      end
      skit_pkg::S_LK_RD: begin
        if (!stat.lk_more) begin
          state_next = skit_pkg::S_LA_RD;
        end
      end
      skit_pkg::S_LK_CMP: begin
        if (stat.lk_hit) begin
          state_next = skit_pkg::S_IDLE;
        end
      end
      skit_pkg::S_LA_CMP: begin
        if (stat.hit) begin
          state_next = skit_pkg::S_IDLE;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    cmd        = '0;
    cmd.status = skit_pkg::ST_DONE;
    busy       = (state != skit_pkg::S_IDLE);
    unique case (state)
      skit_pkg::S_IDLE: begin
        cmd.load = start;
      end
      skit_pkg::S_RESULT: begin
        cmd.is_init = 1'b1;
        cmd.set_status = 1'b1;
        if (stat.func == skit_pkg::FUNC_CLEAR) begin
          cmd.clear  = 1'b1;
          cmd.strobe = 1'b1;
        end else if (stat.func == skit_pkg::FUNC_INSERT) begin
          if (stat.full) begin
            cmd.status = skit_pkg::ST_FULL;
            cmd.strobe = 1'b1;
          end
        end else if (stat.func == skit_pkg::FUNC_LOOKUP) begin
          cmd.lk_init = 1'b1;
          cmd.is_init = 1'b0;
          cmd.status  = skit_pkg::ST_NOT_FOUND;
          if (stat.key_zero || stat.empty) begin
            cmd.strobe = 1'b1;
          end
        end else begin
          cmd.strobe = 1'b1;
        end
      end
      skit_pkg::S_IS_RD: begin
        if (!stat.is_more) begin
          cmd.sh_init = 1'b1;
        end
      end
      skit_pkg::S_IS_CMP: cmd.is_step = 1'b1;
      skit_pkg::S_SH_RD: cmd.sh_rd = 1'b1;
      skit_pkg::S_SH_WR: cmd.sh_wr = 1'b1;
      skit_pkg::S_INS_WR: begin
        cmd.ins_wr = 1'b1;
        cmd.strobe = 1'b1;
      end
      skit_pkg::S_LK_CMP: begin
        if (stat.lk_hit) begin
          cmd.set_found = 1'b1;
          cmd.strobe    = 1'b1;
        end else begin
          cmd.lk_step = 1'b1;
        end
      end
      skit_pkg::S_LA_RD: cmd.rd_a = 1'b1;
      skit_pkg::S_LA_CMP: begin
        if (stat.hit) begin
          cmd.set_found = 1'b1;
          cmd.strobe    = 1'b1;
        end
      end
      skit_pkg::S_LB_RD: cmd.rd_b = 1'b1;
      skit_pkg::S_LB_CMP: begin
        cmd.strobe = 1'b1;
        if (stat.hit) begin
          cmd.set_found = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end
endmodule
`default_nettype wire

// ----- sv/sorted_key_index_table.sv -----
`default_nettype none
// Clear, lookup of key zero, lookup in an empty table and a dropped insert end in S_RESULT.
// An insert binary-searches for its slot, shifts every entry above it up one place, then writes
// the new entry; the table memory moves each shifted entry by a read state and a write state.
// A lookup binary-searches, then probes the range's two ends. One item is in work at a time.
// done strobes the result for one cycle, the first cycle with busy low; it cannot be stalled.
// Synchronous reset empties the table; stored contents are not cleared.
module sorted_key_index_table #(
  parameter int TABLE_DEPTH = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [1:0]  func,
  input  wire logic [31:0] key,
  output logic             busy,
  output logic             done,
  output logic [1:0]       status,
  output logic [9:0]       order_number
);
  skit_pkg::cmd_t  cmd;
  skit_pkg::stat_t stat;
  logic            busy_c;

  skit_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .stat (stat),
    .cmd  (cmd),
    .busy (busy_c)
  );

  skit_datapath #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
    .clk         (clk),
    .rst         (rst),
    .func        (func),
    .key         (key),
    .cmd         (cmd),
    .stat        (stat),
    .status      (status),
    .order_number(order_number),
    .done        (done)
  );

  assign busy = busy_c;
endmodule
`default_nettype wire
